// File: hdl/ntnf_pkg.sv
// ----------------------------------------------------------------------------
// ntnf_pkg: shared types and constants of the nearest tuning note finder
// Field widths, reset values, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ntnf_pkg;

    localparam int NOTE_SLOTS_DEF   = 128;
    localparam int OCTAVE_COUNT_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 7;
    localparam int CENTS_W  = 32;
    localparam int NOTE_W   = 7;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 25;
    localparam int OCTW_W   = 23;
    localparam int CTR_W    = 4;
    localparam int OFS_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int PROD_W   = OCTW_W + CTR_W;

    localparam logic signed [REF_W-1:0] REF_RESET    = 25'sd19200;
    localparam logic [OCTW_W-1:0]       OCTW_RESET   = 23'd76800;
    localparam logic [CTR_W-1:0]        CENTER_RESET = 4'd4;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_BASE,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } t_state;

    // Controls from the sequencer to the candidate datapath
    typedef struct packed {
        logic start;      // load first octave offset, forget best
        logic load_base;  // load octave base pitch and base difference
        logic oct_step;   // advance octave offset by one octave width
        logic issue;      // a table read was issued this cycle
    } t_scan_ctl;

endpackage

`default_nettype wire

// File: hdl/ntnf_mem.sv
// ----------------------------------------------------------------------------
// ntnf_mem: note offset table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntnf_mem
    import ntnf_pkg::*;
#(
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF,
    parameter int ADDR_W     = 7
) (
    input  wire                    i_clk,
    input  wire                    i_wr_en,
    input  wire [ADDR_W-1:0]       i_wr_addr,
    input  wire [OFS_W-1:0]        i_wr_data,
    input  wire [ADDR_W-1:0]       i_rd_addr,
    output logic [OFS_W-1:0]       o_rd_data
);

    logic [OFS_W-1:0] r_mem [NOTE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/ntnf_scan.sv
// ----------------------------------------------------------------------------
// ntnf_scan: candidate pitch datapath
// Builds each candidate pitch from the octave base and the stored offset,
// takes its distance to the query pitch and keeps the best candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module ntnf_scan
    import ntnf_pkg::*;
#(
    parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF,
    parameter int ADDR_W       = 7
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_scan_ctl                   i_ctl,
    input  wire [ADDR_W-1:0]            i_issue_idx,
    input  wire signed [REF_W-1:0]      i_ref_pitch,
    input  wire [OCTW_W-1:0]            i_octave_width,
    input  wire [CTR_W-1:0]             i_center_octave,
    input  wire signed [CENTS_W-1:0]    i_query,
    input  wire [OFS_W-1:0]             i_rd_data,
    output logic                        o_busy,
    output logic [ADDR_W-1:0]           o_best_idx
);

    localparam int OCT_W   = $clog2(OCTAVE_COUNT);
    localparam int DOCT_W  = ((OCT_W > CTR_W) ? OCT_W : CTR_W) + 1;
    localparam int OFF_W   = DOCT_W + OCTW_W;
    localparam int PITCH_W = OFF_W + 2;
    localparam int DIFF_W  = ((PITCH_W > CENTS_W) ? PITCH_W : CENTS_W) + 1;

    logic signed [OFF_W-1:0]   r_oct_off;
    logic signed [PITCH_W-1:0] r_base;
    logic signed [DIFF_W-1:0]  r_bmc;
    logic                      r_rd_vld, r_a_vld, r_b_vld;
    logic [ADDR_W-1:0]         r_rd_idx, r_a_idx, r_b_idx;
    logic signed [PITCH_W-1:0] r_a_pitch, r_b_pitch, r_best_pitch;
    logic signed [DIFF_W-1:0]  r_a_diff;
    logic [DIFF_W-1:0]         r_b_dist, r_best_dist;
    logic                      r_have;
    logic [ADDR_W-1:0]         r_best_idx;

    logic [PROD_W-1:0]         w_prod;
    logic signed [OFS_W-1:0]   w_ofs;
    logic                      w_take;

    assign w_prod = PROD_W'(i_center_octave) * PROD_W'(i_octave_width);
    assign w_ofs  = i_rd_data;

    assign w_take = !r_have || (r_b_dist < r_best_dist)
                    || ((r_b_dist == r_best_dist) && (r_b_pitch < r_best_pitch));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.issue;
            r_a_vld  <= r_rd_vld;
            r_b_vld  <= r_a_vld;
            if (i_ctl.start) begin
                r_have <= 1'b0;
            end else if (r_b_vld) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_oct_off <= OFF_W'(0) - OFF_W'(w_prod);
        end else if (i_ctl.oct_step) begin
            r_oct_off <= r_oct_off + OFF_W'(i_octave_width);
        end
        if (i_ctl.load_base) begin
            r_base <= PITCH_W'(i_ref_pitch) + PITCH_W'(r_oct_off);
            r_bmc  <= DIFF_W'(i_ref_pitch) + DIFF_W'(r_oct_off) - DIFF_W'(i_query);
        end
        // stage A: candidate pitch and signed distance
        r_rd_idx  <= i_issue_idx;
        r_a_idx   <= r_rd_idx;
        r_a_pitch <= r_base + PITCH_W'(w_ofs);
        r_a_diff  <= r_bmc + DIFF_W'(w_ofs);
        // stage B: magnitude
        r_b_idx   <= r_a_idx;
        r_b_pitch <= r_a_pitch;
        r_b_dist  <= r_a_diff[DIFF_W-1] ? DIFF_W'(-r_a_diff) : DIFF_W'(r_a_diff);
        // stage C: keep the best
        if (r_b_vld && w_take) begin
            r_best_dist  <= r_b_dist;
            r_best_pitch <= r_b_pitch;
            r_best_idx   <= r_b_idx;
        end
    end

    assign o_busy     = r_rd_vld | r_a_vld | r_b_vld;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

// File: hdl/ntnf_ctrl.sv
// ----------------------------------------------------------------------------
// ntnf_ctrl: command sequencer
// Accepts items, applies writes and clears, walks octaves and notes for a
// query and holds the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ntnf_ctrl
    import ntnf_pkg::*;
#(
    parameter int NOTE_SLOTS   = NOTE_SLOTS_DEF,
    parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF,
    parameter int ADDR_W       = 7,
    parameter int CNT_W        = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [CMD_W-1:0]             i_command,
    input  wire [SLOT_W-1:0]            i_note_slot,
    input  wire signed [CENTS_W-1:0]    i_cents_value,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [NOTE_W-1:0]           o_nearest_note,
    output logic [STATUS_W-1:0]         o_status,
    output logic                        o_wr_en,
    output logic [ADDR_W-1:0]           o_wr_addr,
    output logic [OFS_W-1:0]            o_wr_data,
    output logic [ADDR_W-1:0]           o_rd_addr,
    output t_scan_ctl                   o_ctl,
    output logic signed [CENTS_W-1:0]   o_query,
    input  wire                         i_busy,
    input  wire [ADDR_W-1:0]            i_best_idx
);

    localparam int OCT_W = $clog2(OCTAVE_COUNT);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [OCT_W-1:0] OCT_LAST = OCT_W'(OCTAVE_COUNT - 1);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_idx;
    logic [OCT_W-1:0]       r_oct;
    logic [STATUS_W-1:0]    r_res_status;
    logic                   r_res_query;
    logic signed [CENTS_W-1:0] r_query;
    logic                   r_out_vld;
    logic [NOTE_W-1:0]      r_out_note;
    logic [STATUS_W-1:0]    r_out_status;

    logic                   w_accept;
    logic [CMP_W-1:0]       w_slot;
    logic                   w_slot_ok;
    logic                   w_range_ok;
    logic                   w_out_free;
    logic                   w_last_idx;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_slot     = CMP_W'(i_note_slot);
    assign w_slot_ok  = (w_slot <= CMP_W'(r_count)) && (w_slot < CMP_W'(NOTE_SLOTS));
    assign w_range_ok = (&i_cents_value[CENTS_W-1:OFS_W-1])
                        || !(|i_cents_value[CENTS_W-1:OFS_W-1]);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_last_idx = (r_idx == r_count - CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_QUERY && r_count != '0) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_INIT:  n_state = S_BASE;
            S_BASE:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_busy) begin
                    n_state = (r_oct == OCT_LAST) ? S_RESP : S_BASE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ctl     = '0;
        o_wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_wr_en = w_accept && (i_command == CMD_WRITE) && w_slot_ok && w_range_ok;
            end
            S_INIT:  o_ctl.start     = 1'b1;
            S_BASE:  o_ctl.load_base = 1'b1;
            S_SCAN:  o_ctl.issue     = 1'b1;
            S_DRAIN: o_ctl.oct_step  = !i_busy && (r_oct != OCT_LAST);
            S_RESP:  o_ctl = '0;
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_command == CMD_CLEAR) begin
                r_count <= '0;
            end else if (o_wr_en && w_slot == CMP_W'(r_count)) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_RESP && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= i_cents_value;
            case (i_command)
                CMD_WRITE: begin
                    r_res_query <= 1'b0;
                    if (!w_slot_ok) begin
                        r_res_status <= ST_BAD_SLOT;
                    end else if (!w_range_ok) begin
                        r_res_status <= ST_BAD_RANGE;
                    end else begin
                        r_res_status <= ST_OK;
                    end
                end
                CMD_QUERY: begin
                    r_res_query  <= (r_count != '0);
                    r_res_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                end
                default: begin
                    r_res_query  <= 1'b0;
                    r_res_status <= ST_OK;
                end
            endcase
        end
        if (r_state == S_INIT) begin
            r_oct <= '0;
        end else if (o_ctl.oct_step) begin
            r_oct <= r_oct + OCT_W'(1);
        end
        if (r_state == S_BASE) begin
            r_idx <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (r_state == S_RESP && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_note   <= r_res_query ? NOTE_W'(i_best_idx) : '0;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_nearest_note = r_out_note;
    assign o_status       = r_out_status;
    assign o_wr_addr      = w_slot[ADDR_W-1:0];
    assign o_wr_data      = i_cents_value[OFS_W-1:0];
    assign o_rd_addr      = r_idx[ADDR_W-1:0];
    assign o_query        = r_query;

endmodule

`default_nettype wire

// File: hdl/nearest_tuning_note_finder_unit.sv
// ----------------------------------------------------------------------------
// nearest_tuning_note_finder_unit: nearest note in a tuning scale
// Stores a scale of note offsets and finds the note nearest a query pitch.
// ----------------------------------------------------------------------------
// A note write, a clear or an unused command goes from the idle state
// straight to the response state. A query with N stored notes walks every
// octave, one candidate per cycle within each octave's scan, through a single
// shared add/compare pipeline fed by the one read port of the note table.
// The input stalls for the whole item; a finished result waits in the output
// register and the next item can be taken while it does. Cents are signed
// with 6 fraction bits; ties go to the lower pitch, then to the earlier note.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce it. o_cfg_ready is always high.
`default_nettype none

module nearest_tuning_note_finder_unit
    import ntnf_pkg::*;
#(
    parameter int NOTE_SLOTS   = NOTE_SLOTS_DEF,
    parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [CMD_W-1:0]             i_command,
    input  wire [SLOT_W-1:0]            i_note_slot,
    input  wire signed [CENTS_W-1:0]    i_cents_value,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [NOTE_W-1:0]           o_nearest_note,
    output logic [STATUS_W-1:0]         o_status,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NOTE_SLOTS + 1);

    logic signed [REF_W-1:0]   r_ref_pitch;
    logic [OCTW_W-1:0]         r_octave_width;
    logic [CTR_W-1:0]          r_center_octave;

    t_scan_ctl                 w_ctl;
    logic                      w_wr_en;
    logic [ADDR_W-1:0]         w_wr_addr;
    logic [OFS_W-1:0]          w_wr_data;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [OFS_W-1:0]          w_rd_data;
    logic signed [CENTS_W-1:0] w_query;
    logic                      w_busy;
    logic [ADDR_W-1:0]         w_best_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_pitch     <= REF_RESET;
            r_octave_width  <= OCTW_RESET;
            r_center_octave <= CENTER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REF:    r_ref_pitch     <= i_cfg_data[REF_W-1:0];
                CFG_OCTW:   r_octave_width  <= i_cfg_data[OCTW_W-1:0];
                CFG_CENTER: r_center_octave <= i_cfg_data[CTR_W-1:0];
                default:    r_ref_pitch     <= r_ref_pitch;
            endcase
        end
    end

    ntnf_ctrl #(
        .NOTE_SLOTS   (NOTE_SLOTS),
        .OCTAVE_COUNT (OCTAVE_COUNT),
        .ADDR_W       (ADDR_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_note_slot    (i_note_slot),
        .i_cents_value  (i_cents_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_nearest_note (o_nearest_note),
        .o_status       (o_status),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_rd_addr      (w_rd_addr),
        .o_ctl          (w_ctl),
        .o_query        (w_query),
        .i_busy         (w_busy),
        .i_best_idx     (w_best_idx)
    );

    ntnf_mem #(
        .NOTE_SLOTS (NOTE_SLOTS),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ntnf_scan #(
        .OCTAVE_COUNT (OCTAVE_COUNT),
        .ADDR_W       (ADDR_W)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_issue_idx     (w_rd_addr),
        .i_ref_pitch     (r_ref_pitch),
        .i_octave_width  (r_octave_width),
        .i_center_octave (r_center_octave),
        .i_query         (w_query),
        .i_rd_data       (w_rd_data),
        .o_busy          (w_busy),
        .o_best_idx      (w_best_idx)
    );

endmodule

`default_nettype wire
